FILE: design/ctbe_pkg.sv
`default_nettype none

package ctbe_pkg;

	// default text capacity in characters
	localparam int CAPACITY_DEF = 1024;

	// the store is split into a row of 2**CELL_BITS cells
	localparam int CELL_BITS = 2;
	localparam int NUM_CELLS = 1 << CELL_BITS;

	// fixed field widths
	localparam int CHAR_W    = 8;
	localparam int IDX_W     = 10;
	localparam int CNT_OUT_W = 11;

	// key codes
	localparam logic [CHAR_W-1:0] KEY_ENTER = 8'h45;
	localparam logic [CHAR_W-1:0] KEY_BACK  = 8'h42;
	localparam logic [CHAR_W-1:0] KEY_DEL   = 8'h44;
	localparam logic [CHAR_W-1:0] KEY_RIGHT = 8'h3E;
	localparam logic [CHAR_W-1:0] KEY_LEFT  = 8'h3C;
	localparam logic [CHAR_W-1:0] NEWLINE   = 8'h0A;

	// whitespace bytes that are ignored
	localparam logic [CHAR_W-1:0] KEY_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] KEY_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] KEY_CR    = 8'h0D;

	// control that travels along the row of cells with each access
	typedef struct packed {
		logic valid;
		logic wr;
	} ctbe_tok_t;

	// item sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_WAIT,
		ST_FINISH
	} ctbe_state_t;

	// decoded item
	typedef enum logic [2:0] {
		OP_READ,
		OP_NOP,
		OP_INSERT,
		OP_BACK,
		OP_DEL,
		OP_RIGHT,
		OP_LEFT
	} ctbe_op_t;

endpackage

`default_nettype wire

FILE: design/ctbe_ram.sv
`default_nettype none

module ctbe_ram #(
	parameter int WIDTH = ctbe_pkg::CHAR_W,
	parameter int DEPTH = ctbe_pkg::CAPACITY_DEF / ctbe_pkg::NUM_CELLS
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: design/ctbe_cell.sv
`default_nettype none

module ctbe_cell #(
	parameter int AW      = $clog2(ctbe_pkg::CAPACITY_DEF),
	parameter int CELL_ID = 0
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ctbe_pkg::ctbe_tok_t           in_tok,
	input  wire logic [AW-1:0]                 in_addr,
	input  wire logic [ctbe_pkg::CHAR_W-1:0]   in_data,
	output ctbe_pkg::ctbe_tok_t                out_tok,
	output logic      [AW-1:0]                 out_addr,
	output logic      [ctbe_pkg::CHAR_W-1:0]   out_data
);

	localparam int BAW   = AW - ctbe_pkg::CELL_BITS;
	localparam int DEPTH = 1 << BAW;

	ctbe_pkg::ctbe_tok_t             tok_q;
	logic [AW-1:0]                   addr_q;
	logic [ctbe_pkg::CHAR_W-1:0]     data_q;
	logic                            hit_q;
	logic                            hit;
	logic [ctbe_pkg::CHAR_W-1:0]     rdata;

	// this cell owns the bank picked by the top address bits
	assign hit = in_tok.valid
		&& (in_addr[AW-1 -: ctbe_pkg::CELL_BITS] == ctbe_pkg::CELL_BITS'(CELL_ID));

	ctbe_ram #(
		.WIDTH (ctbe_pkg::CHAR_W),
		.DEPTH (DEPTH)
	) u_bank (
		.clk   (clk),
		.we    (hit && in_tok.wr),
		.addr  (in_addr[BAW-1:0]),
		.wdata (in_data),
		.rdata (rdata)
	);

	// hand the transaction on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			hit_q <= 1'b0;
		end else begin
			tok_q <= in_tok;
			hit_q <= hit;
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= in_addr;
		data_q <= in_data;
	end

	// a read that hit here picks up the bank data
	assign out_tok  = tok_q;
	assign out_addr = addr_q;
	assign out_data = (hit_q && !tok_q.wr) ? rdata : data_q;

endmodule

`default_nettype wire

FILE: design/cursor_text_buffer_editor_top.sv
`default_nettype none

// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------------
// key      | key_valid, key_stall | cmd, key, read_index
// res      | res_valid, res_stall | read_char, cursor_pos, text_length, overflow
//
// one item at a time: an item that needs no store read holds the block through the
// launch and finish states, its result loaded into the result register on leaving finish;
// a read in range or a cursor move away from an end also holds it in the wait state
// until the access has made its trip through the row of cells.
// reset clears the counts and the handshake state; the store holds no reset.
// a new item is taken while a finished result still waits on res_stall; the
// item after that waits until the result register frees.

module cursor_text_buffer_editor_top #(
	parameter int CAPACITY = ctbe_pkg::CAPACITY_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             key_valid,
	output logic                                  key_stall,
	input  wire logic                             cmd,
	input  wire logic [ctbe_pkg::CHAR_W-1:0]      key,
	input  wire logic [ctbe_pkg::IDX_W-1:0]       read_index,
	output logic                                  res_valid,
	input  wire logic                             res_stall,
	output logic      [ctbe_pkg::CHAR_W-1:0]      read_char,
	output logic      [ctbe_pkg::CNT_OUT_W-1:0]   cursor_pos,
	output logic      [ctbe_pkg::CNT_OUT_W-1:0]   text_length,
	output logic                                  overflow
);

	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int AW_RAW = $clog2(CAPACITY);
	localparam int AW     = (AW_RAW > ctbe_pkg::CELL_BITS) ? AW_RAW : ctbe_pkg::CELL_BITS + 1;
	localparam int XW     = (CW > ctbe_pkg::IDX_W) ? CW : ctbe_pkg::IDX_W;
	localparam int NC     = ctbe_pkg::NUM_CELLS;

	ctbe_pkg::ctbe_state_t           state_q, state_d;
	ctbe_pkg::ctbe_op_t              op;

	logic                            cmd_q;
	logic [ctbe_pkg::CHAR_W-1:0]     key_q;
	logic [ctbe_pkg::IDX_W-1:0]      idx_q;

	logic [CW-1:0]                   before_q, before_d;
	logic [CW-1:0]                   after_q, after_d;
	logic [ctbe_pkg::CHAR_W-1:0]     rc_q, rc_d;
	logic                            ovf_q, ovf_d;

	logic                            res_valid_q;
	logic [ctbe_pkg::CHAR_W-1:0]     read_char_q;
	logic [ctbe_pkg::CNT_OUT_W-1:0]  cursor_pos_q;
	logic [ctbe_pkg::CNT_OUT_W-1:0]  text_length_q;
	logic                            overflow_q;

	logic [CW-1:0]                   len;
	logic                            full;
	logic                            blank;
	logic [ctbe_pkg::CHAR_W-1:0]     ins_char;
	logic [XW-1:0]                   idx_x, before_x, len_x, rd_addr_x;
	logic                            in_range;
	logic                            needs_read;
	logic                            ret;
	logic                            out_free;
	logic                            out_load;
	logic                            accept;

	ctbe_pkg::ctbe_tok_t             tok_c  [NC+1];
	logic [AW-1:0]                   addr_c [NC+1];
	logic [ctbe_pkg::CHAR_W-1:0]     data_c [NC+1];

	// row of store cells
	for (genvar i = 0; i < NC; i++) begin : g_cell
		ctbe_cell #(
			.AW      (AW),
			.CELL_ID (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_tok   (tok_c[i]),
			.in_addr  (addr_c[i]),
			.in_data  (data_c[i]),
			.out_tok  (tok_c[i+1]),
			.out_addr (addr_c[i+1]),
			.out_data (data_c[i+1])
		);
	end

	// read data coming back off the end of the row
	assign ret = tok_c[NC].valid && !tok_c[NC].wr;

	// item capture
	assign accept = key_valid && !key_stall;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			key_q <= key;
			idx_q <= read_index;
		end
	end

	// item decode
	assign blank    = (key_q == ctbe_pkg::KEY_SPACE)
		|| ((key_q >= ctbe_pkg::KEY_TAB) && (key_q <= ctbe_pkg::KEY_CR));
	assign ins_char = (key_q == ctbe_pkg::KEY_ENTER) ? ctbe_pkg::NEWLINE : key_q;

	always_comb begin
		op = ctbe_pkg::OP_INSERT;
		if (cmd_q) begin
			op = ctbe_pkg::OP_READ;
		end else if (blank) begin
			op = ctbe_pkg::OP_NOP;
		end else begin
			unique case (key_q)
				ctbe_pkg::KEY_BACK:  op = ctbe_pkg::OP_BACK;
				ctbe_pkg::KEY_DEL:   op = ctbe_pkg::OP_DEL;
				ctbe_pkg::KEY_RIGHT: op = ctbe_pkg::OP_RIGHT;
				ctbe_pkg::KEY_LEFT:  op = ctbe_pkg::OP_LEFT;
				default:             op = ctbe_pkg::OP_INSERT;
			endcase
		end
	end

	// gap arithmetic
	assign len       = before_q + after_q;
	assign full      = len >= CW'(CAPACITY);
	assign idx_x     = XW'(idx_q);
	assign before_x  = XW'(before_q);
	assign len_x     = XW'(len);
	assign in_range  = idx_x < len_x;
	assign rd_addr_x = (idx_x < before_x) ? idx_x : (XW'(CAPACITY) - len_x + idx_x);

	assign needs_read = ((op == ctbe_pkg::OP_READ) && in_range)
		|| ((op == ctbe_pkg::OP_RIGHT) && (after_q != '0))
		|| ((op == ctbe_pkg::OP_LEFT) && (before_q != '0));

	assign out_free = !res_valid_q || !res_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ctbe_pkg::ST_IDLE: begin
				if (key_valid) begin
					state_d = ctbe_pkg::ST_LAUNCH;
				end
			end
			ctbe_pkg::ST_LAUNCH: begin
				state_d = needs_read ? ctbe_pkg::ST_WAIT : ctbe_pkg::ST_FINISH;
			end
			ctbe_pkg::ST_WAIT: begin
				if (ret) begin
					state_d = ctbe_pkg::ST_FINISH;
				end
			end
			ctbe_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = ctbe_pkg::ST_IDLE;
				end
			end
			default: state_d = ctbe_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: store transactions and count updates
	always_comb begin
		key_stall = 1'b1;
		tok_c[0]  = '0;
		addr_c[0] = '0;
		data_c[0] = '0;
		before_d  = before_q;
		after_d   = after_q;
		rc_d      = rc_q;
		ovf_d     = ovf_q;
		out_load  = 1'b0;
		unique case (state_q)
			ctbe_pkg::ST_IDLE: begin
				key_stall = 1'b0;
			end
			ctbe_pkg::ST_LAUNCH: begin
				rc_d  = '0;
				ovf_d = 1'b0;
				case (op)
					ctbe_pkg::OP_READ: begin
						if (in_range) begin
							tok_c[0].valid = 1'b1;
							addr_c[0]      = AW'(rd_addr_x);
						end
					end
					ctbe_pkg::OP_INSERT: begin
						if (full) begin
							ovf_d = 1'b1;
						end else begin
							tok_c[0].valid = 1'b1;
							tok_c[0].wr    = 1'b1;
							addr_c[0]      = AW'(before_q);
							data_c[0]      = ins_char;
							before_d       = before_q + CW'(1);
						end
					end
					ctbe_pkg::OP_BACK: begin
						if (before_q != '0) begin
							before_d = before_q - CW'(1);
						end
					end
					ctbe_pkg::OP_DEL: begin
						if (after_q != '0) begin
							after_d = after_q - CW'(1);
						end
					end
					ctbe_pkg::OP_RIGHT: begin
						// fetch the first character after the gap
						if (after_q != '0) begin
							tok_c[0].valid = 1'b1;
							addr_c[0]      = AW'(CW'(CAPACITY) - after_q);
						end
					end
					ctbe_pkg::OP_LEFT: begin
						// fetch the last character before the gap
						if (before_q != '0) begin
							tok_c[0].valid = 1'b1;
							addr_c[0]      = AW'(before_q - CW'(1));
						end
					end
					default: begin
					end
				endcase
			end
			ctbe_pkg::ST_WAIT: begin
				if (ret) begin
					case (op)
						ctbe_pkg::OP_RIGHT: begin
							tok_c[0].valid = 1'b1;
							tok_c[0].wr    = 1'b1;
							addr_c[0]      = AW'(before_q);
							data_c[0]      = data_c[NC];
							before_d       = before_q + CW'(1);
							after_d        = after_q - CW'(1);
						end
						ctbe_pkg::OP_LEFT: begin
							tok_c[0].valid = 1'b1;
							tok_c[0].wr    = 1'b1;
							addr_c[0]      = AW'(CW'(CAPACITY) - after_q - CW'(1));
							data_c[0]      = data_c[NC];
							before_d       = before_q - CW'(1);
							after_d        = after_q + CW'(1);
						end
						default: begin
							rc_d = data_c[NC];
						end
					endcase
				end
			end
			ctbe_pkg::ST_FINISH: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	// sequencer and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ctbe_pkg::ST_IDLE;
			before_q <= '0;
			after_q  <= '0;
		end else begin
			state_q  <= state_d;
			before_q <= before_d;
			after_q  <= after_d;
		end
	end

	always_ff @(posedge clk) begin
		rc_q  <= rc_d;
		ovf_q <= ovf_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			read_char_q   <= rc_q;
			cursor_pos_q  <= ctbe_pkg::CNT_OUT_W'(before_q);
			text_length_q <= ctbe_pkg::CNT_OUT_W'(len);
			overflow_q    <= ovf_q;
		end
	end

	assign res_valid   = res_valid_q;
	assign read_char   = read_char_q;
	assign cursor_pos  = cursor_pos_q;
	assign text_length = text_length_q;
	assign overflow    = overflow_q;

endmodule

`default_nettype wire

FILE: tb/cursor_text_buffer_editor_top_test.sv
`timescale 1ns / 1ps

// status the block reports after one item
typedef struct {
	logic [ctbe_pkg::CHAR_W-1:0]    read_char;
	logic [ctbe_pkg::CNT_OUT_W-1:0] cursor_pos;
	logic [ctbe_pkg::CNT_OUT_W-1:0] text_length;
	logic                           overflow;
} buffer_status_t;

localparam int TEXT_CAP = ctbe_pkg::CAPACITY_DEF;

class gap_text_scoreboard;
	// shadow copy of the gap buffer
	logic [ctbe_pkg::CHAR_W-1:0] shadow_text [TEXT_CAP];
	int unsigned                 left_n;
	int unsigned                 right_n;
	buffer_status_t              awaited_status [$];
	int unsigned                 fails;

	function new();
		left_n  = 0;
		right_n = 0;
		fails   = 0;
	endfunction

	function int unsigned text_len();
		return left_n + right_n;
	endfunction

	function int unsigned pending();
		return awaited_status.size();
	endfunction

	// returns 1 when the buffer is full and the character is dropped
	function bit insert_char(logic [ctbe_pkg::CHAR_W-1:0] c);
		if (left_n + right_n >= TEXT_CAP)
			return 1'b1;
		shadow_text[left_n] = c;
		left_n++;
		return 1'b0;
	endfunction

	// apply one accepted transaction and queue the status it should give
	function void apply_item(logic c, logic [ctbe_pkg::CHAR_W-1:0] k,
		logic [ctbe_pkg::IDX_W-1:0] idx);
		buffer_status_t s;
		int unsigned    pos;
		s.read_char = '0;
		s.overflow  = 1'b0;
		if (c) begin
			pos = idx;
			if (pos < left_n)
				s.read_char = shadow_text[pos];
			else if (pos - left_n < right_n)
				s.read_char = shadow_text[TEXT_CAP - right_n + (pos - left_n)];
		end else if (k == ctbe_pkg::KEY_SPACE ||
		             (k >= ctbe_pkg::KEY_TAB && k <= ctbe_pkg::KEY_CR)) begin
			// whitespace is ignored
		end else if (k == ctbe_pkg::KEY_ENTER) begin
			s.overflow = insert_char(ctbe_pkg::NEWLINE);
		end else if (k == ctbe_pkg::KEY_BACK) begin
			if (left_n > 0)
				left_n--;
		end else if (k == ctbe_pkg::KEY_DEL) begin
			if (right_n > 0)
				right_n--;
		end else if (k == ctbe_pkg::KEY_RIGHT) begin
			if (right_n > 0) begin
				shadow_text[left_n] = shadow_text[TEXT_CAP - right_n];
				left_n++;
				right_n--;
			end
		end else if (k == ctbe_pkg::KEY_LEFT) begin
			if (left_n > 0) begin
				right_n++;
				left_n--;
				shadow_text[TEXT_CAP - right_n] = shadow_text[left_n];
			end
		end else begin
			s.overflow = insert_char(k);
		end
		s.cursor_pos  = ctbe_pkg::CNT_OUT_W'(left_n);
		s.text_length = ctbe_pkg::CNT_OUT_W'(left_n + right_n);
		awaited_status.push_back(s);
	endfunction

	function void note_fail(string msg);
		fails++;
		if (fails <= 10)
			$display("[%0t] %s", $time, msg);
	endfunction

	// compare one accepted result transaction with the oldest expectation
	function void check_result(buffer_status_t got);
		buffer_status_t e;
		if (awaited_status.size() == 0) begin
			note_fail($sformatf("unexpected result: char %h cur %0d len %0d ovf %b",
				got.read_char, got.cursor_pos, got.text_length, got.overflow));
			return;
		end
		e = awaited_status.pop_front();
		if (got.read_char !== e.read_char || got.cursor_pos !== e.cursor_pos ||
		    got.text_length !== e.text_length || got.overflow !== e.overflow)
			note_fail($sformatf(
				"mismatch: exp char %h cur %0d len %0d ovf %b, got char %h cur %0d len %0d ovf %b",
				e.read_char, e.cursor_pos, e.text_length, e.overflow,
				got.read_char, got.cursor_pos, got.text_length, got.overflow));
	endfunction
endclass

module cursor_text_buffer_editor_top_test;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           key_valid = 1'b0;
	logic                           key_stall;
	logic                           cmd = 1'b0;
	logic [ctbe_pkg::CHAR_W-1:0]    key = '0;
	logic [ctbe_pkg::IDX_W-1:0]     read_index = '0;
	logic                           res_valid;
	logic                           res_stall = 1'b0;
	logic [ctbe_pkg::CHAR_W-1:0]    read_char;
	logic [ctbe_pkg::CNT_OUT_W-1:0] cursor_pos;
	logic [ctbe_pkg::CNT_OUT_W-1:0] text_length;
	logic                           overflow;

	gap_text_scoreboard sb;
	bit                 no_idle = 1'b0;
	bit                 hold_off_req = 1'b0;

	cursor_text_buffer_editor_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.key_valid   (key_valid),
		.key_stall   (key_stall),
		.cmd         (cmd),
		.key         (key),
		.read_index  (read_index),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.read_char   (read_char),
		.cursor_pos  (cursor_pos),
		.text_length (text_length),
		.overflow    (overflow)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// watch both channels
	always @(posedge clk) begin
		buffer_status_t got;
		if (arst_n) begin
			if (key_valid && !key_stall)
				sb.apply_item(cmd, key, read_index);
			if (res_valid && !res_stall) begin
				got.read_char   = read_char;
				got.cursor_pos  = cursor_pos;
				got.text_length = text_length;
				got.overflow    = overflow;
				sb.check_result(got);
			end
		end
	end

	// result side back-pressure, with one long hold-off on request
	initial begin
		int n;
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				res_stall <= 1'b1;
				repeat (300) @(negedge clk);
				hold_off_req = 1'b0;
			end else if (no_idle) begin
				res_stall <= 1'b0;
				@(negedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					res_stall <= 1'b1;
					repeat (n) @(negedge clk);
				end
				res_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
	end

	// offer one transaction from a falling edge and hold it until taken
	task automatic drive_item(logic c, logic [ctbe_pkg::CHAR_W-1:0] k,
		logic [ctbe_pkg::IDX_W-1:0] idx);
		int gap;
		cmd        <= c;
		key        <= k;
		read_index <= idx;
		key_valid  <= 1'b1;
		do
			@(posedge clk);
		while (key_stall);
		@(negedge clk);
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			key_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// random item with the given percentages; the remainder is whitespace
	task automatic send_random(int ins_pct, int mov_pct, int era_pct, int rd_pct);
		int                          r;
		int unsigned                 len;
		logic                        c;
		logic [ctbe_pkg::CHAR_W-1:0] k;
		logic [ctbe_pkg::IDX_W-1:0]  idx;
		r   = $urandom_range(0, 99);
		c   = 1'b0;
		k   = ctbe_pkg::CHAR_W'($urandom_range(0, 255));
		idx = ctbe_pkg::IDX_W'($urandom_range(0, TEXT_CAP - 1));
		if (r < ins_pct) begin
			if ($urandom_range(0, 9) == 0)
				k = ctbe_pkg::KEY_ENTER;
			else
				do
					k = ctbe_pkg::CHAR_W'($urandom_range(0, 255));
				while (k == ctbe_pkg::KEY_ENTER || k == ctbe_pkg::KEY_BACK ||
				       k == ctbe_pkg::KEY_DEL || k == ctbe_pkg::KEY_RIGHT ||
				       k == ctbe_pkg::KEY_LEFT || k == ctbe_pkg::KEY_SPACE ||
				       (k >= ctbe_pkg::KEY_TAB && k <= ctbe_pkg::KEY_CR));
		end else if (r < ins_pct + mov_pct) begin
			k = $urandom_range(0, 1) ? ctbe_pkg::KEY_LEFT : ctbe_pkg::KEY_RIGHT;
		end else if (r < ins_pct + mov_pct + era_pct) begin
			k = $urandom_range(0, 1) ? ctbe_pkg::KEY_BACK : ctbe_pkg::KEY_DEL;
		end else if (r < ins_pct + mov_pct + era_pct + rd_pct) begin
			c   = 1'b1;
			len = sb.text_len();
			if (len > 0 && $urandom_range(0, 4) != 0)
				idx = ctbe_pkg::IDX_W'($urandom_range(0, len - 1));
		end else begin
			r = $urandom_range(0, 5);
			k = (r == 5) ? ctbe_pkg::KEY_SPACE
				: ctbe_pkg::KEY_TAB + ctbe_pkg::CHAR_W'(r);
		end
		drive_item(c, k, idx);
	endtask

	// stop offering and wait until every result is in
	task automatic drain();
		key_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		int n;
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: ends of the buffer, odd bytes, whitespace, every key
		drive_item(1'b1, 8'h00, 10'd0);
		drive_item(1'b1, 8'hFF, 10'd1023);
		drive_item(1'b0, ctbe_pkg::KEY_BACK, 10'd0);
		drive_item(1'b0, ctbe_pkg::KEY_DEL, 10'd1023);
		drive_item(1'b0, ctbe_pkg::KEY_LEFT, 10'd0);
		drive_item(1'b0, ctbe_pkg::KEY_RIGHT, 10'd0);
		drive_item(1'b0, 8'h00, 10'd0);
		drive_item(1'b0, 8'hFF, 10'd0);
		drive_item(1'b0, ctbe_pkg::KEY_ENTER, 10'd0);
		drive_item(1'b0, 8'h08, 10'd0);
		drive_item(1'b0, 8'h0E, 10'd0);
		drive_item(1'b0, ctbe_pkg::KEY_SPACE, 10'd0);
		drive_item(1'b0, ctbe_pkg::KEY_TAB, 10'd0);
		drive_item(1'b0, ctbe_pkg::KEY_CR, 10'd0);
		drive_item(1'b0, 8'h0B, 10'd0);
		drive_item(1'b0, ctbe_pkg::KEY_LEFT, 10'd0);
		drive_item(1'b0, ctbe_pkg::KEY_LEFT, 10'd0);
		drive_item(1'b0, ctbe_pkg::KEY_DEL, 10'd0);
		drive_item(1'b0, ctbe_pkg::KEY_BACK, 10'd0);
		drive_item(1'b0, ctbe_pkg::KEY_RIGHT, 10'd0);
		drive_item(1'b1, 8'h00, 10'd0);
		drive_item(1'b1, 8'h00, 10'd1);
		drive_item(1'b1, 8'h00, 10'd2);
		drive_item(1'b1, 8'h00, 10'd3);

		// mixed editing on a short text, long receiver hold-off midway
		for (int i = 0; i < 250; i++) begin
			if (i == 120)
				hold_off_req = 1'b1;
			send_random(35, 25, 15, 20);
		end
		drain();

		// fill the buffer to capacity, one stretch with no idling
		n = 0;
		while (sb.text_len() < TEXT_CAP) begin
			no_idle = (n >= 300 && n < 500);
			send_random(88, 5, 2, 5);
			n++;
		end
		no_idle = 1'b0;

		// full buffer: dropped inserts, moves, reads over the whole text
		for (int i = 0; i < 150; i++)
			send_random(40, 25, 10, 20);

		drain();
		repeat (20) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("cursor_text_buffer_editor_top_test: PASS");
		else
			$display("cursor_text_buffer_editor_top_test: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#8_000_000;
		$display("cursor_text_buffer_editor_top_test: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
design/ctbe_pkg.sv
design/ctbe_ram.sv
design/ctbe_cell.sv
design/cursor_text_buffer_editor_top.sv
tb/cursor_text_buffer_editor_top_test.sv
